[rtl/core/rtr_pkg.sv]
// shared constants and types for the reliable transport receiver
`timescale 1ns / 1ps

package rtr_pkg;

    localparam int MAX_CONNECTIONS = 32;
    localparam int IDX_W           = $clog2(MAX_CONNECTIONS);
    localparam int CNT_W           = $clog2(MAX_CONNECTIONS + 1);

    localparam int CID_W   = 16;
    localparam int SEQ_W   = 32;
    localparam int LEN_W   = 10;
    localparam int CFG_A_W = 2;

    localparam logic [CFG_A_W-1:0] CFG_SERVER_ISN = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_SEQ    = 2'd1;

    localparam logic [SEQ_W-1:0] SERVER_ISN_RST = 32'd4321;
    localparam logic [SEQ_W-1:0] MAX_SEQ_RST    = 32'd102400;

    localparam logic [1:0] VERDICT_UNKNOWN = 2'd0;
    localparam logic [1:0] VERDICT_HANDLED = 2'd1;
    localparam logic [1:0] VERDICT_RECV    = 2'd2;
    localparam logic [1:0] VERDICT_FULL    = 2'd3;

    typedef struct packed {
        logic load;
        logic read_stage;
        logic calc_stage;
        logic commit;
    } t_cmd;

endpackage

[rtl/core/rtr_ctrl.sv]
// sequencing state machine for the receiver
`timescale 1ns / 1ps

module rtr_ctrl
    import rtr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CALC;
            ST_CALC: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_cmd.load       = (r_state == ST_IDLE) && i_start;
    assign o_cmd.read_stage = (r_state == ST_READ);
    assign o_cmd.calc_stage = (r_state == ST_CALC);
    assign o_cmd.commit     = (r_state == ST_DONE);

endmodule

[rtl/core/rtr_dpath.sv]
// connection table, sequence arithmetic and reply registers
`timescale 1ns / 1ps

module rtr_dpath
    import rtr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_index,
    input  logic [SEQ_W-1:0]   i_cfg_data,
    input  logic [CID_W-1:0]   i_conn_id,
    input  logic [SEQ_W-1:0]   i_seq_num,
    input  logic               i_syn_bit,
    input  logic               i_fin_bit,
    input  logic [LEN_W-1:0]   i_payload_len,
    output logic               o_done,
    output logic [1:0]         o_verdict,
    output logic               o_send_reply,
    output logic [SEQ_W-1:0]   o_reply_seq,
    output logic [SEQ_W-1:0]   o_reply_ack,
    output logic [CID_W-1:0]   o_reply_conn,
    output logic               o_reply_ack_bit,
    output logic               o_reply_syn_bit,
    output logic               o_reply_fin_bit,
    output logic               o_reply_is_dup,
    output logic               o_accept_payload
);

    localparam logic [CID_W-1:0] CID_LIMIT = CID_W'(MAX_CONNECTIONS);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CONNECTIONS);

    logic [SEQ_W-1:0] r_srv_isn;
    logic [SEQ_W-1:0] r_max_seq;

    logic [SEQ_W-1:0] r_mem [MAX_CONNECTIONS];
    logic [MAX_CONNECTIONS-1:0] r_active_map;
    logic [MAX_CONNECTIONS-1:0] r_fin_map;
    logic [CNT_W-1:0] r_next_conn;

    logic [CID_W-1:0] r_cid;
    logic             r_cid_ok;
    logic [SEQ_W-1:0] r_seq;
    logic             r_syn;
    logic             r_fin;
    logic [LEN_W-1:0] r_len;
    logic [SEQ_W-1:0] r_exp;

    logic             r_match;
    logic [SEQ_W:0]   r_sum;
    logic [SEQ_W-1:0] r_seq1;
    logic [SEQ_W-1:0] r_s1;
    logic             r_act;
    logic             r_fseen;
    logic [SEQ_W-1:0] r_nx;

    logic [IDX_W-1:0] w_idx;
    logic [IDX_W-1:0] n_widx;
    logic             n_we;
    logic [SEQ_W-1:0] n_wdata;
    logic             n_open;
    logic             n_set_fin;
    logic [1:0]       n_verdict;
    logic             n_send;
    logic [SEQ_W-1:0] n_rseq;
    logic [SEQ_W-1:0] n_rack;
    logic [CID_W-1:0] n_rconn;
    logic             n_rsyn;
    logic             n_rfin;
    logic             n_rdup;
    logic             n_accept;

    logic             r_done;
    logic [1:0]       r_verdict;
    logic             r_send;
    logic [SEQ_W-1:0] r_rseq;
    logic [SEQ_W-1:0] r_rack;
    logic [CID_W-1:0] r_rconn;
    logic             r_rackb;
    logic             r_rsyn;
    logic             r_rfin;
    logic             r_rdup;
    logic             r_accept;

    assign w_idx = r_cid[IDX_W-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srv_isn <= SERVER_ISN_RST;
            r_max_seq <= MAX_SEQ_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SERVER_ISN) begin
                r_srv_isn <= i_cfg_data;
            end else if (i_cfg_index == CFG_MAX_SEQ) begin
                r_max_seq <= i_cfg_data;
            end
        end
    end

    // request capture, table read and arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cid    <= i_conn_id;
            r_cid_ok <= (i_conn_id < CID_LIMIT);
            r_seq    <= i_seq_num;
            r_syn    <= i_syn_bit;
            r_fin    <= i_fin_bit;
            r_len    <= i_payload_len;
            r_exp    <= r_mem[i_conn_id[IDX_W-1:0]];
        end
        if (i_cmd.read_stage) begin
            r_match <= (r_seq == r_exp);
            r_sum   <= {1'b0, r_seq} + {{(SEQ_W + 1 - LEN_W){1'b0}}, r_len};
            r_seq1  <= r_seq + 32'd1;
            r_s1    <= r_srv_isn + 32'd1;
            r_act   <= r_active_map[w_idx];
            r_fseen <= r_fin_map[w_idx];
        end
        if (i_cmd.calc_stage) begin
            if (r_sum > {1'b0, r_max_seq}) begin
                r_nx <= SEQ_W'(r_sum - {1'b0, r_max_seq} - 33'd1);
            end else begin
                r_nx <= r_sum[SEQ_W-1:0];
            end
        end
    end

    always_comb begin
        n_widx    = w_idx;
        n_we      = 1'b0;
        n_wdata   = r_nx;
        n_open    = 1'b0;
        n_set_fin = 1'b0;
        n_verdict = VERDICT_UNKNOWN;
        n_send    = 1'b0;
        n_rseq    = '0;
        n_rack    = '0;
        n_rconn   = '0;
        n_rsyn    = 1'b0;
        n_rfin    = 1'b0;
        n_rdup    = 1'b0;
        n_accept  = 1'b0;
        if (!r_cid_ok || (r_cid != '0 && !r_act) || (r_cid == '0 && !r_syn)) begin
            n_verdict = VERDICT_UNKNOWN;
        end else if (r_cid == '0) begin
            if (r_next_conn >= CNT_LIMIT) begin
                n_verdict = VERDICT_FULL;
            end else begin
                n_verdict = VERDICT_RECV;
                n_open    = 1'b1;
                n_widx    = r_next_conn[IDX_W-1:0];
                n_we      = 1'b1;
                n_wdata   = r_seq1;
                n_send    = 1'b1;
                n_rseq    = r_srv_isn;
                n_rack    = r_seq1;
                n_rconn   = CID_W'(r_next_conn);
                n_rsyn    = 1'b1;
            end
        end else begin
            n_verdict = (r_syn || !r_match) ? VERDICT_HANDLED : VERDICT_RECV;
            n_rconn   = r_cid;
            if (r_match && !r_syn && r_fin) begin
                n_send    = 1'b1;
                n_rseq    = r_s1;
                n_rack    = r_seq1;
                n_rfin    = 1'b1;
                n_we      = 1'b1;
                n_wdata   = r_seq1;
                n_set_fin = 1'b1;
            end else if (!r_match) begin
                n_send = 1'b1;
                n_rack = r_exp;
                n_rdup = 1'b1;
                if (r_syn) begin
                    n_rseq = r_srv_isn;
                    n_rsyn = 1'b1;
                end else begin
                    n_rseq = r_s1;
                    n_rfin = r_fin;
                end
            end else if (!r_fseen) begin
                n_we     = 1'b1;
                n_wdata  = r_nx;
                n_accept = 1'b1;
                if (r_len != '0) begin
                    n_send = 1'b1;
                    n_rseq = r_s1;
                    n_rack = r_nx;
                end
            end
        end
        if (!n_send) begin
            n_rconn = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_we) begin
            r_mem[n_widx] <= n_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_map <= '0;
            r_fin_map    <= '0;
            r_next_conn  <= CNT_W'(1);
            r_done       <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                if (n_open) begin
                    r_active_map[n_widx] <= 1'b1;
                    r_fin_map[n_widx]    <= 1'b0;
                    r_next_conn          <= r_next_conn + CNT_W'(1);
                end
                if (n_set_fin) begin
                    r_fin_map[n_widx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_verdict <= n_verdict;
            r_send    <= n_send;
            r_rseq    <= n_rseq;
            r_rack    <= n_rack;
            r_rconn   <= n_rconn;
            r_rackb   <= n_send;
            r_rsyn    <= n_rsyn;
            r_rfin    <= n_rfin;
            r_rdup    <= n_rdup;
            r_accept  <= n_accept;
        end
    end

    assign o_done           = r_done;
    assign o_verdict        = r_verdict;
    assign o_send_reply     = r_send;
    assign o_reply_seq      = r_rseq;
    assign o_reply_ack      = r_rack;
    assign o_reply_conn     = r_rconn;
    assign o_reply_ack_bit  = r_rackb;
    assign o_reply_syn_bit  = r_rsyn;
    assign o_reply_fin_bit  = r_rfin;
    assign o_reply_is_dup   = r_rdup;
    assign o_accept_payload = r_accept;

endmodule

[rtl/core/reliable_transport_receiver.sv]
// top level of the reliable transport receiver
//
//  channel  | control              | data
//  ---------+----------------------+----------------------------------------
//  request  | i_start / o_busy     | i_conn_id .. i_payload_len
//  result   | o_done (one cycle)   | o_verdict .. o_accept_payload
//  config   | i_cfg_valid / ready  | i_cfg_index, i_cfg_data
//
// each request runs through capture with table read, compare and add,
// wrap compare and subtract, and commit; the result strobe follows in the next
// cycle while the block already takes a new request
// synchronous active-low reset clears the connection marks and sets the id counter to 1
// the result side cannot stall; config is always ready
`timescale 1ns / 1ps

module reliable_transport_receiver
    import rtr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [CID_W-1:0]   i_conn_id,
    input  logic [SEQ_W-1:0]   i_seq_num,
    input  logic [SEQ_W-1:0]   i_ack_num,
    input  logic               i_ack_bit,
    input  logic               i_syn_bit,
    input  logic               i_fin_bit,
    input  logic [LEN_W-1:0]   i_payload_len,
    output logic               o_done,
    output logic [1:0]         o_verdict,
    output logic               o_send_reply,
    output logic [SEQ_W-1:0]   o_reply_seq,
    output logic [SEQ_W-1:0]   o_reply_ack,
    output logic [CID_W-1:0]   o_reply_conn,
    output logic               o_reply_ack_bit,
    output logic               o_reply_syn_bit,
    output logic               o_reply_fin_bit,
    output logic               o_reply_is_dup,
    output logic               o_accept_payload,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_A_W-1:0] i_cfg_index,
    input  logic [SEQ_W-1:0]   i_cfg_data
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    rtr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd)
    );

    rtr_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_conn_id        (i_conn_id),
        .i_seq_num        (i_seq_num),
        .i_syn_bit        (i_syn_bit),
        .i_fin_bit        (i_fin_bit),
        .i_payload_len    (i_payload_len),
        .o_done           (o_done),
        .o_verdict        (o_verdict),
        .o_send_reply     (o_send_reply),
        .o_reply_seq      (o_reply_seq),
        .o_reply_ack      (o_reply_ack),
        .o_reply_conn     (o_reply_conn),
        .o_reply_ack_bit  (o_reply_ack_bit),
        .o_reply_syn_bit  (o_reply_syn_bit),
        .o_reply_fin_bit  (o_reply_fin_bit),
        .o_reply_is_dup   (o_reply_is_dup),
        .o_accept_payload (o_accept_payload)
    );

endmodule

[rtl/core/rtr_checker.sv]
// port-level checks for the receiver, bound to the top level
`timescale 1ns / 1ps

module rtr_checker
    import rtr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input logic [1:0]         o_verdict,
    input logic               o_send_reply,
    input logic [SEQ_W-1:0]   o_reply_seq,
    input logic [SEQ_W-1:0]   o_reply_ack,
    input logic [CID_W-1:0]   o_reply_conn,
    input logic               o_reply_ack_bit,
    input logic               o_reply_syn_bit,
    input logic               o_reply_fin_bit,
    input logic               o_reply_is_dup,
    input logic               o_accept_payload
);

    // every request yields its result a fixed time after it is taken
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> ##3 o_done)
        else $error("result strobe missing after request");

    a_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request not taken");

    a_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_send_reply) |-> (o_reply_seq == '0 && o_reply_ack == '0 &&
            o_reply_conn == '0 && !o_reply_ack_bit && !o_reply_syn_bit &&
            !o_reply_fin_bit && !o_reply_is_dup))
        else $error("reply fields set without reply");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_accept_payload) |->
            (o_verdict == VERDICT_RECV || o_verdict == VERDICT_HANDLED))
        else $error("payload accepted on a dropped request");

    a_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_reply_is_dup) |-> (o_verdict == VERDICT_HANDLED && !o_accept_payload))
        else $error("duplicate ack with wrong verdict");

endmodule

bind reliable_transport_receiver rtr_checker u_checker (.*);
